FILE: rtl/lfu_cache_lru_tiebreak_assert.svh
// assertion macros used by the cache port checker
`ifndef LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH

// clocked property, quiet while reset is asserted
`define LFUC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// same-cycle implication
`define LFUC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	`LFUC_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

FILE: rtl/lfuc_pkg.sv
// shared constants and types of the lfu cache
package lfuc_pkg;

	localparam int KEY_W           = 32;
	localparam int VAL_W           = 32;
	localparam int STAMP_W         = 48;
	localparam int CAP_W           = 5;
	localparam int ENTRIES_DEF     = 16;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	// what a scan has found so far
	typedef struct packed {
		logic match;
		logic free;
		logic victim;
	} scan_flags_t;

endpackage

FILE: rtl/lfuc_if.sv
// request and response channel interfaces of the lfu cache
interface lfuc_req_if;
	logic                               valid;
	logic                               ready;
	logic                               operation;
	logic signed [lfuc_pkg::KEY_W-1:0]  key;
	logic signed [lfuc_pkg::VAL_W-1:0]  value;

	modport source (output valid, output operation, output key, output value, input ready);
	modport sink (input valid, input operation, input key, input value, output ready);
endinterface

interface lfuc_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               hit;
	logic signed [lfuc_pkg::VAL_W-1:0]  read_value;
	logic                               evicted;
	logic signed [lfuc_pkg::KEY_W-1:0]  evicted_key;

	modport source (output valid, output hit, output read_value, output evicted,
		output evicted_key, input ready);
	modport sink (input valid, input hit, input read_value, input evicted,
		input evicted_key, output ready);
endinterface

FILE: rtl/lfuc_ram.sv
// generic simple dual-port ram with registered read
module lfuc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/lfuc_scan.sv
// scan unit: key match, first free slot and lfu/lru victim over streamed entries
module lfuc_scan #(
	parameter int ENTRIES     = lfuc_pkg::ENTRIES_DEF,
	parameter int COUNT_WIDTH = lfuc_pkg::COUNT_WIDTH_DEF,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int VO    = lfuc_pkg::KEY_W,
	localparam int CO    = VO + lfuc_pkg::VAL_W,
	localparam int SO    = CO + COUNT_WIDTH,
	localparam int ENT_W = SO + lfuc_pkg::STAMP_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          ent_vld,
	input  logic [IDX_W-1:0]              ent_idx,
	input  logic                          ent_valid,
	input  logic [ENT_W-1:0]              ent_data,
	input  logic [lfuc_pkg::KEY_W-1:0]    key,
	output lfuc_pkg::scan_flags_t         flags,
	output logic [IDX_W-1:0]              match_idx,
	output logic [lfuc_pkg::VAL_W-1:0]    match_value,
	output logic [COUNT_WIDTH-1:0]        match_count,
	output logic [IDX_W-1:0]              free_idx,
	output logic [IDX_W-1:0]              victim_idx,
	output logic [lfuc_pkg::KEY_W-1:0]    victim_key
);

	lfuc_pkg::scan_flags_t              flags_q;
	logic [IDX_W-1:0]                   match_idx_q;
	logic [lfuc_pkg::VAL_W-1:0]         match_value_q;
	logic [COUNT_WIDTH-1:0]             match_count_q;
	logic [IDX_W-1:0]                   free_idx_q;
	logic [IDX_W-1:0]                   victim_idx_q;
	logic [lfuc_pkg::KEY_W-1:0]         victim_key_q;
	logic [COUNT_WIDTH-1:0]             victim_count_q;
	logic [lfuc_pkg::STAMP_W-1:0]       victim_stamp_q;

	logic [lfuc_pkg::KEY_W-1:0]         e_key;
	logic [lfuc_pkg::VAL_W-1:0]         e_value;
	logic [COUNT_WIDTH-1:0]             e_count;
	logic [lfuc_pkg::STAMP_W-1:0]       e_stamp;
	logic                               take_match;
	logic                               take_free;
	logic                               take_victim;

	always_comb begin
		e_key   = ent_data[0 +: lfuc_pkg::KEY_W];
		e_value = ent_data[VO +: lfuc_pkg::VAL_W];
		e_count = ent_data[CO +: COUNT_WIDTH];
		e_stamp = ent_data[SO +: lfuc_pkg::STAMP_W];

		take_match  = ent_vld && ent_valid && !flags_q.match && (e_key == key);
		take_free   = ent_vld && !ent_valid && !flags_q.free;
		// strict compares keep the lowest index on a full tie
		take_victim = ent_vld && ent_valid && (!flags_q.victim ||
			(e_count < victim_count_q) ||
			((e_count == victim_count_q) && (e_stamp < victim_stamp_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (clear) begin
			flags_q <= '0;
		end else begin
			if (take_match) flags_q.match <= 1'b1;
			if (take_free) flags_q.free <= 1'b1;
			if (take_victim) flags_q.victim <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_match) begin
			match_idx_q   <= ent_idx;
			match_value_q <= e_value;
			match_count_q <= e_count;
		end
		if (take_free) begin
			free_idx_q <= ent_idx;
		end
		if (take_victim) begin
			victim_idx_q   <= ent_idx;
			victim_key_q   <= e_key;
			victim_count_q <= e_count;
			victim_stamp_q <= e_stamp;
		end
	end

	assign flags       = flags_q;
	assign match_idx   = match_idx_q;
	assign match_value = match_value_q;
	assign match_count = match_count_q;
	assign free_idx    = free_idx_q;
	assign victim_idx  = victim_idx_q;
	assign victim_key  = victim_key_q;

endmodule

FILE: rtl/lfu_cache_lru_tiebreak.sv
// top level of the fully associative lfu cache with lru tie-break
// Fully associative key/value cache of ENTRIES entries with least-frequently-used
// replacement; equal use counts fall back to the oldest access stamp, then to the
// lowest slot. Key, value, use count and stamp of every slot sit in one ram with a
// registered read; valid bits, occupancy and the 48-bit access clock are flops.
// Each request (get or put) runs through the states in order: idle for the
// transfer, scan streaming every slot through the single ram read port into the
// scan unit, drain for the last read to land, and commit, which writes the touched
// slot back and loads the response register. The response register lets the next
// request in while a response still waits; a commit only stalls when that register
// is still full. capacity (cfg_we/cfg_wdata, reset 16) limits how many slots are
// filled, values above ENTRIES act as ENTRIES, zero turns puts into pure lookups.
// Write it only while no request is in flight. Use counts saturate at
// 2^COUNT_WIDTH-1.
module lfu_cache_lru_tiebreak #(
	parameter int ENTRIES     = lfuc_pkg::ENTRIES_DEF,
	parameter int COUNT_WIDTH = lfuc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lfuc_pkg::CAP_W-1:0]  cfg_wdata,
	lfuc_req_if.sink                    req,
	lfuc_rsp_if.source                  rsp
);

	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W   = $clog2(ENTRIES + 1);
	localparam int CMP_W   = (OCC_W > lfuc_pkg::CAP_W) ? OCC_W : lfuc_pkg::CAP_W;
	localparam int ENT_W   = lfuc_pkg::KEY_W + lfuc_pkg::VAL_W + COUNT_WIDTH
		+ lfuc_pkg::STAMP_W;
	localparam int STAMP_W = lfuc_pkg::STAMP_W;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [IDX_W-1:0]               rd_idx_q;
	logic                           rd_vld_s1;
	logic [IDX_W-1:0]               rd_idx_s1;

	// request held for the whole scan
	lfuc_pkg::op_t                  op_q;
	logic [lfuc_pkg::KEY_W-1:0]     key_q;
	logic [lfuc_pkg::VAL_W-1:0]     val_q;

	logic [lfuc_pkg::CAP_W-1:0]     capacity_q;
	logic [ENTRIES-1:0]             valid_q;
	logic [OCC_W-1:0]               occ_q;
	logic [STAMP_W-1:0]             clock_q;

	// response register
	logic                           rsp_vld_q;
	logic                           rsp_hit_q;
	logic [lfuc_pkg::VAL_W-1:0]     rsp_rd_q;
	logic                           rsp_ev_q;
	logic [lfuc_pkg::KEY_W-1:0]     rsp_evk_q;

	// scan results
	lfuc_pkg::scan_flags_t          flags;
	logic [IDX_W-1:0]               match_idx;
	logic [lfuc_pkg::VAL_W-1:0]     match_value;
	logic [COUNT_WIDTH-1:0]         match_count;
	logic [IDX_W-1:0]               free_idx;
	logic [IDX_W-1:0]               victim_idx;
	logic [lfuc_pkg::KEY_W-1:0]     victim_key;

	logic [ENT_W-1:0]               ram_rdata;
	logic [ENT_W-1:0]               ram_wdata;
	logic [IDX_W-1:0]               ram_waddr;
	logic                           ram_we;

	logic                           req_xfer;
	logic                           scan_last;
	logic                           out_free;
	logic                           commit_go;
	logic                           is_put;
	logic                           cap_nz;
	logic [CMP_W-1:0]               cap_eff;
	logic                           room;
	logic                           upd_hit;
	logic                           do_ins;
	logic                           use_free;
	logic                           use_victim;
	logic                           ins_ok;
	logic [IDX_W-1:0]               slot;
	logic [STAMP_W-1:0]             stamp_nx;
	logic [COUNT_WIDTH-1:0]         count_nx;
	logic [lfuc_pkg::VAL_W-1:0]     value_nx;

	assign req_xfer  = req.valid && req.ready;
	assign scan_last = (rd_idx_q == IDX_W'(ENTRIES - 1));
	assign out_free  = !rsp_vld_q || rsp.ready;
	assign commit_go = (state_q == ST_COMMIT) && out_free;
	assign req.ready = (state_q == ST_IDLE);

	// entry store, read one slot per scan cycle, written once at commit
	lfuc_ram #(
		.WIDTH (ENT_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	lfuc_scan #(
		.ENTRIES     (ENTRIES),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (req_xfer),
		.ent_vld     (rd_vld_s1),
		.ent_idx     (rd_idx_s1),
		.ent_valid   (valid_q[rd_idx_s1]),
		.ent_data    (ram_rdata),
		.key         (key_q),
		.flags       (flags),
		.match_idx   (match_idx),
		.match_value (match_value),
		.match_count (match_count),
		.free_idx    (free_idx),
		.victim_idx  (victim_idx),
		.victim_key  (victim_key)
	);

	// commit decision from the finished scan
	always_comb begin
		is_put  = (op_q == lfuc_pkg::OP_PUT);
		cap_nz  = (capacity_q != '0);
		// capacity beyond the physical size acts as the physical size
		cap_eff = (CMP_W'(capacity_q) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES)
			: CMP_W'(capacity_q);
		room    = CMP_W'(occ_q) < cap_eff;

		upd_hit    = flags.match && (!is_put || cap_nz);
		do_ins     = !flags.match && is_put && cap_nz;
		use_free   = room && flags.free;
		// below capacity but no free slot cannot happen; a victim then wins
		use_victim = !use_free && flags.victim;
		ins_ok     = do_ins && (use_free || use_victim || flags.free);
		slot       = use_victim ? victim_idx : free_idx;

		stamp_nx = clock_q + STAMP_W'(1);
		count_nx = (&match_count) ? match_count : match_count + COUNT_WIDTH'(1);
		value_nx = is_put ? val_q : match_value;

		ram_we    = commit_go && (upd_hit || ins_ok);
		ram_waddr = upd_hit ? match_idx : slot;
		ram_wdata = upd_hit ? {stamp_nx, count_nx, value_nx, key_q}
			: {stamp_nx, COUNT_WIDTH'(1), val_q, key_q};
	end

	// sequencer and scan address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					rd_idx_q <= '0;
					if (req.valid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx_q;
		if (req_xfer) begin
			op_q  <= lfuc_pkg::op_t'(req.operation);
			key_q <= req.key;
			val_q <= req.value;
		end
	end

	// configuration, valid bits, occupancy and access clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lfuc_pkg::CAP_RESET;
			valid_q    <= '0;
			occ_q      <= '0;
			clock_q    <= '0;
		end else begin
			if (cfg_we) capacity_q <= cfg_wdata;
			if (ram_we) clock_q <= stamp_nx;
			// an eviction refills the same slot, so valid and occupancy stay put
			if (commit_go && ins_ok) begin
				valid_q[slot] <= 1'b1;
				if (!use_victim) occ_q <= occ_q + OCC_W'(1);
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (commit_go) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_go) begin
			rsp_hit_q <= flags.match;
			rsp_rd_q  <= (flags.match && !is_put) ? match_value : '0;
			rsp_ev_q  <= do_ins && use_victim;
			rsp_evk_q <= (do_ins && use_victim) ? victim_key : '0;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.hit         = rsp_hit_q;
	assign rsp.read_value  = rsp_rd_q;
	assign rsp.evicted     = rsp_ev_q;
	assign rsp.evicted_key = rsp_evk_q;

endmodule

FILE: rtl/lfuc_checker.sv
// port-level checker of the lfu cache and its bind
`include "lfu_cache_lru_tiebreak_assert.svh"

module lfuc_port_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_hit,
	input logic [lfuc_pkg::VAL_W-1:0]  rsp_read_value,
	input logic                        rsp_evicted,
	input logic [lfuc_pkg::KEY_W-1:0]  rsp_evicted_key
);

	// one request at a time: busy right after a transfer
	`LFUC_ASSERT(a_busy_after_xfer, clk, arst_n,
		(req_valid && req_ready) |=> !req_ready, "request taken while busy")

	// the scan is still running, so no response can appear right after a transfer
	`LFUC_ASSERT(a_no_early_rsp, clk, arst_n,
		(req_valid && req_ready) |=> !$rose(rsp_valid), "response came before scan finished")

	// only a put miss evicts
	`LFUC_ASSERT_IMPLIES(a_evict_on_miss, clk, arst_n, rsp_valid && rsp_evicted,
		!rsp_hit, "eviction reported on a hit")

	// a nonzero read value only comes from a hit and never with an eviction
	`LFUC_ASSERT_IMPLIES(a_read_on_hit, clk, arst_n, rsp_valid && (rsp_read_value != '0),
		rsp_hit && !rsp_evicted && (rsp_evicted_key == '0), "read value without a hit")

endmodule

bind lfu_cache_lru_tiebreak lfuc_port_checker u_lfuc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_hit         (rsp.hit),
	.rsp_read_value  (rsp.read_value),
	.rsp_evicted     (rsp.evicted),
	.rsp_evicted_key (rsp.evicted_key)
);

FILE: sim/lfuc_checker.sv
// response checker for the lfu cache: predicts every response and compares it field by field
module lfuc_checker #(
	parameter int ENTRIES     = lfuc_pkg::ENTRIES_DEF,
	parameter int COUNT_WIDTH = lfuc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lfuc_pkg::CAP_W-1:0] cfg_wdata,
	lfuc_req_if                        req,
	lfuc_rsp_if                        rsp,
	output int                         fail_count,
	output int                         pending,
	output int                         hits_seen,
	output int                         evictions_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	typedef struct packed {
		logic                       hit;
		logic [lfuc_pkg::VAL_W-1:0] read_value;
		logic                       evicted;
		logic [lfuc_pkg::KEY_W-1:0] evicted_key;
	} access_result_t;

	// shadow copy of the cache contents
	logic                         slot_valid [ENTRIES];
	logic [lfuc_pkg::KEY_W-1:0]   slot_key   [ENTRIES];
	logic [lfuc_pkg::VAL_W-1:0]   slot_value [ENTRIES];
	logic [COUNT_WIDTH-1:0]       slot_uses  [ENTRIES];
	logic [lfuc_pkg::STAMP_W-1:0] slot_stamp [ENTRIES];
	logic [lfuc_pkg::STAMP_W-1:0] touch_clock;
	int                           fill_level;
	logic [lfuc_pkg::CAP_W-1:0]   capacity_reg;

	access_result_t expected_q [$];
	access_result_t want;
	access_result_t predicted;
	int             errs;
	int             hit_total;
	int             evict_total;
	int             r;

	function automatic int first_free_slot();
		int i;
		for (i = 0; i < ENTRIES; i++)
			if (!slot_valid[i])
				return i;
		return -1;
	endfunction

	// one get or put against the shadow cache; updates it and returns the response
	function automatic access_result_t predict_access(input lfuc_pkg::op_t op,
			input logic [lfuc_pkg::KEY_W-1:0] k, input logic [lfuc_pkg::VAL_W-1:0] v);
		access_result_t res;
		int             limit;
		int             idx;
		int             slot;
		int             i;
		res   = '0;
		limit = (int'(capacity_reg) > ENTRIES) ? ENTRIES : int'(capacity_reg);
		idx   = -1;
		for (i = 0; i < ENTRIES; i++)
			if (idx < 0 && slot_valid[i] && slot_key[i] == k)
				idx = i;
		res.hit = (idx >= 0);
		if (idx >= 0 && (op == lfuc_pkg::OP_GET || limit != 0)) begin
			if (op == lfuc_pkg::OP_GET)
				res.read_value = slot_value[idx];
			else
				slot_value[idx] = v;
			if (slot_uses[idx] != COUNT_MAX)
				slot_uses[idx] = slot_uses[idx] + 1'b1;
			touch_clock     = touch_clock + 1'b1;
			slot_stamp[idx] = touch_clock;
		end else if (idx < 0 && op == lfuc_pkg::OP_PUT && limit != 0) begin
			slot = -1;
			if (fill_level < limit)
				slot = first_free_slot();
			if (slot < 0) begin
				// fewest uses first, oldest stamp on equal counts, lowest slot last
				for (i = 0; i < ENTRIES; i++)
					if (slot_valid[i] && (slot < 0 || slot_uses[i] < slot_uses[slot] ||
							(slot_uses[i] == slot_uses[slot] &&
							slot_stamp[i] < slot_stamp[slot])))
						slot = i;
				if (slot >= 0) begin
					res.evicted     = 1'b1;
					res.evicted_key = slot_key[slot];
					slot_valid[slot] = 1'b0;
					if (fill_level > 0)
						fill_level--;
				end else begin
					slot = first_free_slot();
				end
			end
			if (slot >= 0) begin
				slot_valid[slot] = 1'b1;
				slot_key[slot]   = k;
				slot_value[slot] = v;
				slot_uses[slot]  = COUNT_WIDTH'(1);
				touch_clock      = touch_clock + 1'b1;
				slot_stamp[slot] = touch_clock;
				fill_level++;
			end
		end
		return res;
	endfunction

	task automatic report_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		errs++;
		$display("%0t: %s expected %h, actual %h", $time, name, exp_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (r = 0; r < ENTRIES; r++)
				slot_valid[r] = 1'b0;
			touch_clock  = '0;
			fill_level   = 0;
			capacity_reg = lfuc_pkg::CAP_RESET;
			expected_q.delete();
			errs        = 0;
			hit_total   = 0;
			evict_total = 0;
		end else begin
			if (cfg_we)
				capacity_reg = cfg_wdata;
			// responses first, so a response can never match the request of the same edge
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					errs++;
					$display("%0t: response expected none, actual hit=%b", $time, rsp.hit);
				end else begin
					want = expected_q[0];
					expected_q.delete(0);
					if (rsp.hit !== want.hit)
						report_field("hit", want.hit, rsp.hit);
					if (rsp.read_value !== want.read_value)
						report_field("read_value", want.read_value, rsp.read_value);
					if (rsp.evicted !== want.evicted)
						report_field("evicted", want.evicted, rsp.evicted);
					if (rsp.evicted_key !== want.evicted_key)
						report_field("evicted_key", want.evicted_key, rsp.evicted_key);
					hit_total   += want.hit;
					evict_total += want.evicted;
				end
			end
			if (req.valid && req.ready) begin
				predicted  = predict_access(lfuc_pkg::op_t'(req.operation), req.key,
					req.value);
				expected_q = {expected_q, predicted};
			end
		end
		fail_count     <= errs;
		pending        <= expected_q.size();
		hits_seen      <= hit_total;
		evictions_seen <= evict_total;
	end

endmodule

FILE: sim/lfu_cache_lru_tiebreak_tb.sv
// top of the lfu cache testbench: clock, reset, request and response stimulus, verdict
module lfu_cache_lru_tiebreak_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES         = lfuc_pkg::ENTRIES_DEF;
	// leave slack after an access before touching the register
	localparam int SETTLE_CYCLES   = ENTRIES + 8;
	localparam int LONG_HOLD       = 400;
	// longest legal quiet stretch is the long hold plus one access and a config pause,
	// taken several times over
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int ITEMS_PER_PHASE = 75;
	localparam int PHASES          = 8;
	localparam int POOL_MAX        = 24;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we;
	logic [lfuc_pkg::CAP_W-1:0]   cfg_wdata;

	lfuc_req_if req_ch ();
	lfuc_rsp_if rsp_ch ();

	int fail_count;
	int pending;
	int hits_seen;
	int evictions_seen;

	int issued;
	int settings_run;
	int idle_cycles;
	bit hold_rsp_now = 1'b0;

	// keys reused within a phase so that hits and evictions actually happen
	logic [lfuc_pkg::KEY_W-1:0] key_pool [POOL_MAX];

	lfu_cache_lru_tiebreak u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	lfuc_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.fail_count     (fail_count),
		.pending        (pending),
		.hits_seen      (hits_seen),
		.evictions_seen (evictions_seen)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// offer one request, wait for its transfer, then maybe leave a gap
	task automatic issue(input lfuc_pkg::op_t op, input logic [31:0] k, input logic [31:0] v,
			input bit gapless);
		int gap;
		int roll;
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.key       <= k;
		req_ch.value     <= v;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		issued++;
		roll = $urandom_range(0, 99);
		if (gapless || roll < 55)
			gap = 0;
		else if (roll < 92)
			gap = $urandom_range(1, 4);
		else
			gap = $urandom_range(12, 40);
		if (gap > 0) begin
			// junk on the idle bus must not leak into the cache
			req_ch.valid     <= 1'b0;
			req_ch.operation <= 1'($urandom_range(0, 1));
			req_ch.key       <= $urandom();
			req_ch.value     <= $urandom();
			repeat (gap) @(posedge clk);
		end
	endtask

	// drain the cache, let the last access finish, then write the capacity
	task automatic set_capacity(input logic [lfuc_pkg::CAP_W-1:0] cap);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	// response side: random stalls, long ready stretches, and one long hold on request
	initial begin
		int stall;
		int roll;
		int open_for;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			roll = $urandom_range(0, 99);
			if (hold_rsp_now) begin
				hold_rsp_now = 1'b0;
				stall = LONG_HOLD;
			end else if (roll < 50) begin
				stall = 0;
			end else if (roll < 90) begin
				stall = $urandom_range(1, 4);
			end else begin
				stall = $urandom_range(10, 40);
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			open_for = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
			repeat (open_for) @(posedge clk);
		end
	end

	// watchdog: too long without any transfer means the block is stuck
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int           p;
		int           n;
		int           cap;
		int           pool_n;
		int           roll;
		bit           gapless;
		lfuc_pkg::op_t op;
		logic [31:0]  k;
		int           phase_caps [PHASES];
		phase_caps = '{16, 1, 0, 31, 5, 8, 17, 0};
		issued       = 0;
		settings_run = 0;
		req_ch.valid     <= 1'b0;
		req_ch.operation <= lfuc_pkg::OP_GET;
		req_ch.key       <= '0;
		req_ch.value     <= '0;
		cfg_we           <= 1'b0;
		cfg_wdata        <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of key and value at the reset capacity
		issue(lfuc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0);   // miss on empty cache
		issue(lfuc_pkg::OP_PUT, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
		issue(lfuc_pkg::OP_PUT, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
		issue(lfuc_pkg::OP_PUT, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
		issue(lfuc_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0);
		issue(lfuc_pkg::OP_GET, 32'h8000_0000, 32'h1111_1111, 1'b0);
		issue(lfuc_pkg::OP_GET, 32'h7fff_ffff, 32'h0000_0000, 1'b0);
		issue(lfuc_pkg::OP_GET, 32'hffff_ffff, 32'h0000_0000, 1'b0);
		// put on a hit overwrites and reads back zero
		issue(lfuc_pkg::OP_PUT, 32'hffff_ffff, 32'h1234_5678, 1'b0);
		issue(lfuc_pkg::OP_GET, 32'hffff_ffff, 32'h0000_0000, 1'b0);
		issue(lfuc_pkg::OP_GET, 32'h5555_5555, 32'h0000_0000, 1'b0);

		// capacity below occupancy: entries stay, each put miss evicts the least used
		set_capacity(5'd2);
		issue(lfuc_pkg::OP_PUT, 32'haaaa_aaaa, 32'h5555_5555, 1'b0);
		issue(lfuc_pkg::OP_PUT, 32'h5555_5555, 32'haaaa_aaaa, 1'b0);
		issue(lfuc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b0);
		issue(lfuc_pkg::OP_PUT, 32'h3333_3333, 32'h0000_0001, 1'b0);

		// capacity zero: puts change nothing but still report presence, gets still look up
		set_capacity(5'd0);
		issue(lfuc_pkg::OP_PUT, 32'h7fff_ffff, 32'h0000_0001, 1'b0);
		issue(lfuc_pkg::OP_PUT, 32'h0123_4567, 32'h0000_0002, 1'b0);
		issue(lfuc_pkg::OP_GET, 32'h7fff_ffff, 32'h0000_0000, 1'b0);
		issue(lfuc_pkg::OP_GET, 32'h0123_4567, 32'h0000_0000, 1'b0);

		// capacity above the entry count acts as a full cache
		set_capacity(5'd31);
		issue(lfuc_pkg::OP_PUT, 32'h0000_0001, 32'hdead_beef, 1'b0);
		issue(lfuc_pkg::OP_GET, 32'h0000_0001, 32'h0000_0000, 1'b0);

		// random phases, each under its own capacity
		for (p = 0; p < PHASES; p++) begin
			cap = (p == PHASES - 1) ? $urandom_range(0, 31) : phase_caps[p];
			set_capacity(cap[lfuc_pkg::CAP_W-1:0]);
			// keep the old pool when puts are disabled so gets find what is stored
			if (cap != 0) begin
				pool_n = ((cap > ENTRIES) ? ENTRIES : cap) + $urandom_range(1, 8);
				if (pool_n > POOL_MAX)
					pool_n = POOL_MAX;
				for (n = 0; n < pool_n; n++)
					key_pool[n] = $urandom();
			end else if (pool_n < 2) begin
				pool_n = 2;
			end
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				// long response hold while requests keep coming, so the input stalls
				if (p == 3 && n == 5)
					hold_rsp_now = 1'b1;
				// pause the requests until every response is back
				if (n == 60) begin
					req_ch.valid <= 1'b0;
					@(posedge clk);
					wait (pending == 0);
					@(posedge clk);
				end
				gapless = (n >= 40 && n < 56) || (p == 3 && n >= 5 && n < 30);
				roll = $urandom_range(0, 99);
				op   = ($urandom_range(0, 99) < 55) ? lfuc_pkg::OP_PUT : lfuc_pkg::OP_GET;
				k    = (roll < 85) ? key_pool[$urandom_range(0, pool_n - 1)] : $urandom();
				issue(op, k, $urandom(), gapless);
			end
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d requests across %0d capacity settings, a long response hold",
			issued, settings_run + 1);
		$display("and drained pauses; %0d hits and %0d evictions checked", hits_seen,
			evictions_seen);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
